@@ hw/rtl/aewt_pkg.sv @@
// Shared types and codes for the active event window table.
// Used by aewt_cell and active_event_window_table_top; no dependencies.
`timescale 1ns / 1ps

package aewt_pkg;

    // Default number of table entries (one cell per entry)
    localparam int AEWT_CAPACITY = 16;

    // Field widths fixed by the interface
    localparam int CMD_W    = 2;
    localparam int ID_W     = 32;
    localparam int TIME_W   = 64;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FIND  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    // Command token that walks down the cell chain, one cell per cycle.
    // t_start holds the start time for add and the flush time for flush.
    typedef struct packed {
        logic              valid;
        logic [CMD_W-1:0]  cmd;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] t_start;
        logic [TIME_W-1:0] t_end;
        logic              found;   // id matched in some cell passed so far
        logic              placed;  // a free cell has reserved the new entry
    } tok_t;

    // Broadcast from the chain tail back to every cell
    typedef struct packed {
        logic clear;   // drop any reservation
        logic commit;  // turn the reservation into a live entry
    } ctl_t;

endpackage

@@ hw/rtl/aewt_cell.sv @@
// One table entry with its slice of the command chain.
// Depends on aewt_pkg for the token and control types.
`timescale 1ns / 1ps

module aewt_cell
    import aewt_pkg::*;
#(
    parameter int CNT_W = COUNT_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  tok_t             tok_in,
    input  logic [CNT_W-1:0] cnt_in,
    input  ctl_t             ctl,
    output tok_t             tok_out,
    output logic [CNT_W-1:0] cnt_out
);

    logic              valid_reg;
    logic              pending_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] start_reg;
    logic [TIME_W-1:0] end_reg;

    logic              hit;
    logic              outside;
    logic              reserve;
    logic              drop;
    logic              valid_after;
    tok_t              tok_out_reg;
    logic [CNT_W-1:0]  cnt_out_reg;

    // Per-cell match, window test and free-slot reservation
    always_comb begin
        hit     = valid_reg && (id_reg == tok_in.id);
        outside = ($signed(tok_in.t_start) < $signed(start_reg)) ||
                  ($signed(end_reg) < $signed(tok_in.t_start));
        reserve = tok_in.valid && (tok_in.cmd == CMD_ADD) && !valid_reg &&
                  !tok_in.placed;
        drop    = tok_in.valid && (tok_in.cmd == CMD_FLUSH) && valid_reg && outside;
        valid_after = valid_reg && !drop;
    end

    // Entry state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            pending_reg <= 1'b0;
        end else begin
            if (drop) begin
                valid_reg <= 1'b0;
            end else if (ctl.commit && pending_reg) begin
                valid_reg <= 1'b1;
            end
            if (reserve) begin
                pending_reg <= 1'b1;
            end else if (ctl.clear) begin
                pending_reg <= 1'b0;
            end
        end
    end

    // Entry payload, written when the slot is reserved
    always_ff @(posedge aclk) begin
        if (reserve) begin
            id_reg    <= tok_in.id;
            start_reg <= tok_in.t_start;
            end_reg   <= tok_in.t_end;
        end
    end

    // Hand the token and running count to the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_out_reg.valid <= 1'b0;
        end else begin
            tok_out_reg.valid <= tok_in.valid;
        end
        tok_out_reg.cmd     <= tok_in.cmd;
        tok_out_reg.id      <= tok_in.id;
        tok_out_reg.t_start <= tok_in.t_start;
        tok_out_reg.t_end   <= tok_in.t_end;
        tok_out_reg.found   <= tok_in.found || hit;
        tok_out_reg.placed  <= tok_in.placed || reserve;
        cnt_out_reg         <= cnt_in + CNT_W'(valid_after);
    end

    assign tok_out = tok_out_reg;
    assign cnt_out = cnt_out_reg;

endmodule

@@ hw/rtl/active_event_window_table_top.sv @@
// Top level of the active event window table: input stage, cell chain, result stage.
// Depends on aewt_pkg and aewt_cell.
`timescale 1ns / 1ps

// Holds up to CAPACITY timed events (id, start, inclusive end) in a row of
// CAPACITY cells. Each request enters as a token that walks the row one cell
// per cycle, collecting id matches, reserving the first free cell for an add,
// dropping entries outside the flush time, and counting live entries. At the
// end of the row the add is committed or cancelled and the status is formed.
// On acceptance the input register forms end = start + duration - 1; the
// token then passes through the register of each cell, the status is
// registered in the result stage and the result then moves into the output
// register. s_ready returns the cycle after the result moves to the output
// register, so no new request is accepted while one is in flight. If the
// previous result is still unread when the next one reaches the result
// stage, it waits there and s_ready stays low until the output register is
// taken.
// The table is empty after reset and needs no clearing pass.

module active_event_window_table_top
    import aewt_pkg::*;
#(
    parameter int CAPACITY = AEWT_CAPACITY
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [CMD_W-1:0]           s_cmd,
    input  logic signed [ID_W-1:0]     s_event_id,
    input  logic signed [TIME_W-1:0]   s_start_time,
    input  logic signed [TIME_W-1:0]   s_duration,
    input  logic signed [TIME_W-1:0]   s_now_time,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [STATUS_W-1:0]        m_status,
    output logic [COUNT_W-1:0]         m_active_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    tok_t             tok_chain [CAPACITY+1];
    logic [CNT_W-1:0] cnt_chain [CAPACITY+1];
    ctl_t             ctl;

    tok_t                  head_reg;
    logic                  busy_reg;
    logic                  res_valid_reg;
    logic [STATUS_W-1:0]   res_status_reg;
    logic [CNT_W-1:0]      res_count_reg;
    logic                  m_valid_reg;
    logic [STATUS_W-1:0]   m_status_reg;
    logic [COUNT_W-1:0]    m_count_reg;

    tok_t                  tail;
    logic                  accept;
    logic                  move;
    logic [STATUS_W-1:0]   status_next;
    logic [CNT_W-1:0]      count_next;
    logic [COUNT_W+CNT_W-1:0] count_wide;

    assign accept = s_valid && s_ready;
    assign s_ready = !busy_reg;
    assign move = res_valid_reg && (!m_valid_reg || m_ready);

    // Input stage: build the token, with the end time for an add
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg.valid <= 1'b0;
        end else begin
            head_reg.valid <= accept;
        end
        if (accept) begin
            head_reg.cmd     <= s_cmd;
            head_reg.id      <= s_event_id;
            head_reg.t_start <= (s_cmd == CMD_FLUSH) ? s_now_time : s_start_time;
            head_reg.t_end   <= s_start_time + s_duration - TIME_W'(1);
            head_reg.found   <= 1'b0;
            head_reg.placed  <= 1'b0;
        end
    end

    assign tok_chain[0] = head_reg;
    assign cnt_chain[0] = '0;

    // Row of entry cells
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        aewt_cell #(
            .CNT_W(CNT_W)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_in  (tok_chain[gi]),
            .cnt_in  (cnt_chain[gi]),
            .ctl     (ctl),
            .tok_out (tok_chain[gi+1]),
            .cnt_out (cnt_chain[gi+1])
        );
    end

    // Tail: commit or cancel the reservation, form the status
    assign tail = tok_chain[CAPACITY];

    always_comb begin
        ctl.clear  = tail.valid;
        ctl.commit = tail.valid && (tail.cmd == CMD_ADD) && !tail.found && tail.placed;
        count_next = cnt_chain[CAPACITY] + CNT_W'(ctl.commit);
        case (tail.cmd)
            CMD_ADD: begin
                if (tail.found) begin
                    status_next = ST_PRESENT;
                end else if (tail.placed) begin
                    status_next = ST_OK;
                end else begin
                    status_next = ST_FULL;
                end
            end
            CMD_FIND: begin
                if (tail.id[ID_W-1]) begin
                    status_next = ST_INVALID;
                end else if (tail.found) begin
                    status_next = ST_OK;
                end else begin
                    status_next = ST_NOT_FOUND;
                end
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    // Result stage and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                busy_reg <= 1'b1;
            end else if (move) begin
                busy_reg <= 1'b0;
            end
            if (tail.valid) begin
                res_valid_reg <= 1'b1;
            end else if (move) begin
                res_valid_reg <= 1'b0;
            end
            if (move) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign count_wide = {{COUNT_W{1'b0}}, res_count_reg};

    always_ff @(posedge aclk) begin
        if (tail.valid) begin
            res_status_reg <= status_next;
            res_count_reg  <= count_next;
        end
        if (move) begin
            m_status_reg <= res_status_reg;
            m_count_reg  <= count_wide[COUNT_W-1:0];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_active_count = m_count_reg;

endmodule
